FILE: hw/rtl/rrts_pkg.sv
// rrts_pkg: shared types and codes of the round-robin thread scheduler
// slot status codes, request codes, result codes and the slot flag bundle
// no dependencies
`timescale 1ns / 1ps

package rrts_pkg;

  typedef logic [2:0] status_t;
  typedef logic [2:0] req_t;
  typedef logic [2:0] rcode_t;

  // slot status
  localparam status_t ST_EMPTY      = 3'd0;
  localparam status_t ST_READY      = 3'd1;
  localparam status_t ST_DEAD       = 3'd2;
  localparam status_t ST_WAITS      = 3'd3;
  localparam status_t ST_ALARM      = 3'd4;
  localparam status_t ST_WAIT_ALARM = 3'd5;

  // request types
  localparam req_t REQ_CREATE    = 3'd0;
  localparam req_t REQ_KILL      = 3'd1;
  localparam req_t REQ_WAIT      = 3'd2;
  localparam req_t REQ_TIMED     = 3'd3;
  localparam req_t REQ_SLEEP     = 3'd4;
  localparam req_t REQ_SIGNAL    = 3'd5;
  localparam req_t REQ_YIELD     = 3'd6;
  localparam req_t REQ_RUN       = 3'd7;

  // result codes
  localparam rcode_t RC_OK       = 3'd0;
  localparam rcode_t RC_ILLEGAL  = 3'd1;
  localparam rcode_t RC_FULL     = 3'd2;
  localparam rcode_t RC_ALARMS   = 3'd3;
  localparam rcode_t RC_DEADLOCK = 3'd4;
  localparam rcode_t RC_ALL_DEAD = 3'd5;

  // classification of the slot under the shared compare unit
  typedef struct packed {
    logic is_ready;
    logic is_free;
    logic is_live;
    logic is_sleep;
    logic is_alarm;
    logic is_wait_alarm;
    logic wake_due;
    logic cond_match;
  } slot_flags_t;

endpackage

FILE: hw/rtl/round_robin_thread_scheduler_core.sv
// round_robin_thread_scheduler_core: top level, request sequencer and slot table
// uses rrts_pkg, rrts_ram (condition and wake time stores), rrts_slot_eval
`timescale 1ns / 1ps

// channel | direction | handshake         | payload
// in_     | input     | in_valid/in_stall | req_type, thread_id, cond_id, duration, now
// out_    | output    | out_valid/out_stall | result_code, result_thread, switched, counts
//
// one request at a time: run, rejected requests and a kill of a thread that is not
// running go from dispatch straight to done; create scans for the lowest free slot, signal
// scans every slot, and a request that schedules runs the alarm scan over the slot rams,
// one slot a cycle, then the round-robin search, one slot a cycle
// reset clears the status table, counters, running thread and pointer; rams are not cleared
// a request waits in its final state only while the previous result is still stalled

module round_robin_thread_scheduler_core #(
  parameter int NUM_THREADS = 8,
  parameter int COND_BITS   = 16,
  parameter int TIME_BITS   = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_req_type,
  input  logic [2:0]  in_thread_id,
  input  logic [15:0] in_cond_id,
  input  logic [15:0] in_duration,
  input  logic [31:0] in_now,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_result_code,
  output logic [2:0]  out_result_thread,
  output logic        out_switched,
  output logic [3:0]  out_live_count,
  output logic [3:0]  out_sleeping_count,
  output logic [3:0]  out_alarm_count
);

  localparam int TW = $clog2(NUM_THREADS);
  localparam int CW = $clog2(NUM_THREADS + 1);
  localparam logic [TW-1:0] LAST  = TW'(NUM_THREADS - 1);
  localparam logic [CW-1:0] CFULL = CW'(NUM_THREADS);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;
  localparam logic [2:0] S_CREATE = 3'd2;
  localparam logic [2:0] S_WAKE   = 3'd3;
  localparam logic [2:0] S_RR     = 3'd4;
  localparam logic [2:0] S_SIG    = 3'd5;
  localparam logic [2:0] S_DONE   = 3'd6;

  logic [2:0] state_r, state_nxt;

  // latched transaction
  rrts_pkg::req_t       req_r;
  logic [2:0]           tid_r;
  logic [COND_BITS-1:0] cond_r;
  logic [TIME_BITS-1:0] dur_r;
  logic [TIME_BITS-1:0] now_r;
  logic [TW-1:0]        old_r;

  // scheduler state
  rrts_pkg::status_t status_r [NUM_THREADS];
  logic [TW-1:0]     running_r, running_nxt;
  logic [TW-1:0]     ptr_r, ptr_nxt;
  logic [CW-1:0]     live_r, live_nxt;
  logic [CW-1:0]     sleep_r, sleep_nxt;
  logic [CW-1:0]     alarm_r, alarm_nxt;

  // scan control
  logic [TW-1:0] idx_r, idx_nxt;        // ram read address / create index
  logic [TW-1:0] eidx_r, eidx_nxt;      // slot under evaluation
  logic          pv_r, pv_nxt;          // evaluation stage holds a slot
  logic          iss_done_r, iss_done_nxt;
  logic          brk_r, brk_nxt;        // alarm count ran out, no more wakes
  logic [TW-1:0] cnt_r, cnt_nxt;        // round-robin steps taken
  logic          created_r, created_nxt;
  logic [TW-1:0] crt_idx_r, crt_idx_nxt;
  rrts_pkg::rcode_t code_r, code_nxt;

  // output register
  logic             out_valid_r;
  rrts_pkg::rcode_t out_code_r;
  logic [2:0]       out_thread_r;
  logic             out_sw_r;
  logic [3:0]       out_live_r, out_sleep_r, out_alarm_r;

  // status table port
  logic [TW-1:0]     st_addr;
  rrts_pkg::status_t st_rd;
  logic              st_we;
  rrts_pkg::status_t st_wdata;

  // slot rams
  logic                 cond_we, wake_we;
  logic [COND_BITS-1:0] cond_rd;
  logic [TIME_BITS-1:0] wake_rd;
  logic [TIME_BITS-1:0] wake_sum;

  rrts_pkg::slot_flags_t flags;

  logic          accept;
  logic          tid_ok;
  logic [TW-1:0] tid_idx;
  logic [TW-1:0] rr_next;
  logic          out_free;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign tid_ok   = (32'(tid_r) < NUM_THREADS);
  assign tid_idx  = TW'(tid_r);
  assign rr_next  = (ptr_r == LAST) ? '0 : ptr_r + 1'b1;
  assign wake_sum = now_r + dur_r;
  assign st_rd    = status_r[st_addr];
  assign out_free = !out_valid_r || !out_stall;

  rrts_ram #(.WIDTH(COND_BITS), .DEPTH(NUM_THREADS)) u_cond_ram (
    .clk   (clk),
    .we    (cond_we),
    .waddr (running_r),
    .wdata (cond_r),
    .raddr (idx_r),
    .rdata (cond_rd)
  );

  rrts_ram #(.WIDTH(TIME_BITS), .DEPTH(NUM_THREADS)) u_wake_ram (
    .clk   (clk),
    .we    (wake_we),
    .waddr (running_r),
    .wdata (wake_sum),
    .raddr (idx_r),
    .rdata (wake_rd)
  );

  rrts_slot_eval #(.COND_BITS(COND_BITS), .TIME_BITS(TIME_BITS)) u_eval (
    .status    (st_rd),
    .wake_time (wake_rd),
    .now       (now_r),
    .slot_cond (cond_rd),
    .req_cond  (cond_r),
    .flags     (flags)
  );

  always_comb begin
    state_nxt    = state_r;
    running_nxt  = running_r;
    ptr_nxt      = ptr_r;
    live_nxt     = live_r;
    sleep_nxt    = sleep_r;
    alarm_nxt    = alarm_r;
    idx_nxt      = idx_r;
    eidx_nxt     = eidx_r;
    pv_nxt       = 1'b0;
    iss_done_nxt = iss_done_r;
    brk_nxt      = brk_r;
    cnt_nxt      = cnt_r;
    created_nxt  = created_r;
    crt_idx_nxt  = crt_idx_r;
    code_nxt     = code_r;
    st_addr      = running_r;
    st_we        = 1'b0;
    st_wdata     = rrts_pkg::ST_DEAD;
    cond_we      = 1'b0;
    wake_we      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt   = S_DISP;
          created_nxt = 1'b0;
          code_nxt    = rrts_pkg::RC_OK;
        end
      end

      S_DISP: begin
        // restart the scan pipeline for whichever phase comes next
        idx_nxt      = '0;
        iss_done_nxt = 1'b0;
        brk_nxt      = 1'b0;
        unique case (req_r)
          rrts_pkg::REQ_CREATE: begin
            if (live_r < CFULL) begin
              state_nxt = S_CREATE;
            end else begin
              code_nxt  = rrts_pkg::RC_FULL;
              state_nxt = S_DONE;
            end
          end
          rrts_pkg::REQ_KILL: begin
            st_addr = tid_idx;
            if (!tid_ok) begin
              code_nxt  = rrts_pkg::RC_ILLEGAL;
              state_nxt = S_DONE;
            end else begin
              // a live slot leaves every counter it was counted in
              if (flags.is_live && live_r != '0)   live_nxt  = live_r - 1'b1;
              if (flags.is_sleep && sleep_r != '0) sleep_nxt = sleep_r - 1'b1;
              if (flags.is_alarm && alarm_r != '0) alarm_nxt = alarm_r - 1'b1;
              st_we    = 1'b1;
              st_wdata = rrts_pkg::ST_DEAD;
              state_nxt = (tid_idx == running_r) ? S_WAKE : S_DONE;
            end
          end
          rrts_pkg::REQ_WAIT, rrts_pkg::REQ_TIMED, rrts_pkg::REQ_SLEEP: begin
            st_addr = running_r;
            if (!flags.is_ready) begin
              code_nxt  = rrts_pkg::RC_ILLEGAL;
              state_nxt = S_DONE;
            end else begin
              st_we = 1'b1;
              if (req_r == rrts_pkg::REQ_WAIT) begin
                st_wdata  = rrts_pkg::ST_WAITS;
                cond_we   = 1'b1;
                sleep_nxt = sleep_r + 1'b1;
              end else if (req_r == rrts_pkg::REQ_TIMED) begin
                st_wdata  = rrts_pkg::ST_WAIT_ALARM;
                cond_we   = 1'b1;
                wake_we   = 1'b1;
                sleep_nxt = sleep_r + 1'b1;
                alarm_nxt = alarm_r + 1'b1;
              end else begin
                st_wdata  = rrts_pkg::ST_ALARM;
                wake_we   = 1'b1;
                alarm_nxt = alarm_r + 1'b1;
              end
              state_nxt = S_WAKE;
            end
          end
          rrts_pkg::REQ_SIGNAL: begin
            state_nxt = S_SIG;
          end
          rrts_pkg::REQ_YIELD: begin
            state_nxt = S_WAKE;
          end
          rrts_pkg::REQ_RUN: begin
            st_addr = tid_idx;
            if (!tid_ok || !flags.is_ready) begin
              code_nxt = rrts_pkg::RC_ILLEGAL;
            end else begin
              running_nxt = tid_idx;
            end
            state_nxt = S_DONE;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end

      S_CREATE: begin
        // lowest empty or dead slot, one slot a cycle
        st_addr = idx_r;
        if (flags.is_free) begin
          st_we       = 1'b1;
          st_wdata    = rrts_pkg::ST_READY;
          live_nxt    = live_r + 1'b1;
          created_nxt = 1'b1;
          crt_idx_nxt = idx_r;
          state_nxt   = S_DONE;
        end else if (idx_r == LAST) begin
          code_nxt  = rrts_pkg::RC_FULL;
          state_nxt = S_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end

      S_WAKE, S_SIG: begin
        // issue a ram read each cycle, evaluate the slot whose read was issued in the cycle before
        pv_nxt   = !iss_done_r;
        eidx_nxt = idx_r;
        if (!iss_done_r) begin
          if (idx_r == LAST) iss_done_nxt = 1'b1;
          else               idx_nxt      = idx_r + 1'b1;
        end
        st_addr = eidx_r;
        if (pv_r) begin
          if (state_r == S_WAKE) begin
            if (flags.is_alarm && flags.wake_due && !brk_r) begin
              if (flags.is_wait_alarm && sleep_r != '0) sleep_nxt = sleep_r - 1'b1;
              if (alarm_r != '0) alarm_nxt = alarm_r - 1'b1;
              // the alarm sweep stops once the count reaches zero
              if (alarm_r <= CW'(1)) brk_nxt = 1'b1;
              st_we    = 1'b1;
              st_wdata = rrts_pkg::ST_READY;
            end
          end else begin
            if (flags.is_sleep && flags.cond_match) begin
              if (flags.is_wait_alarm && alarm_r != '0) alarm_nxt = alarm_r - 1'b1;
              if (sleep_r != '0) sleep_nxt = sleep_r - 1'b1;
              st_we    = 1'b1;
              st_wdata = rrts_pkg::ST_READY;
            end
          end
          if (eidx_r == LAST) begin
            cnt_nxt   = '0;
            state_nxt = (state_r == S_WAKE) ? S_RR : S_DONE;
          end
        end
      end

      S_RR: begin
        // advance the pointer and test one slot a cycle
        st_addr = rr_next;
        ptr_nxt = rr_next;
        cnt_nxt = cnt_r + 1'b1;
        if (flags.is_ready) begin
          running_nxt = rr_next;
          code_nxt    = rrts_pkg::RC_OK;
          state_nxt   = S_DONE;
        end else if (cnt_r == LAST) begin
          if (alarm_r != '0)     code_nxt = rrts_pkg::RC_ALARMS;
          else if (live_r != '0) code_nxt = rrts_pkg::RC_DEADLOCK;
          else                   code_nxt = rrts_pkg::RC_ALL_DEAD;
          state_nxt = S_DONE;
        end
      end

      S_DONE: begin
        if (out_free) state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      running_r   <= '0;
      ptr_r       <= '0;
      live_r      <= '0;
      sleep_r     <= '0;
      alarm_r     <= '0;
      pv_r        <= 1'b0;
      iss_done_r  <= 1'b0;
      brk_r       <= 1'b0;
      created_r   <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < NUM_THREADS; i++) begin
        status_r[i] <= rrts_pkg::ST_EMPTY;
      end
    end else begin
      state_r    <= state_nxt;
      running_r  <= running_nxt;
      ptr_r      <= ptr_nxt;
      live_r     <= live_nxt;
      sleep_r    <= sleep_nxt;
      alarm_r    <= alarm_nxt;
      pv_r       <= pv_nxt;
      iss_done_r <= iss_done_nxt;
      brk_r      <= brk_nxt;
      created_r  <= created_nxt;
      if (st_we) begin
        status_r[st_addr] <= st_wdata;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload and scan registers, no reset needed
  always_ff @(posedge clk) begin
    idx_r     <= idx_nxt;
    eidx_r    <= eidx_nxt;
    cnt_r     <= cnt_nxt;
    crt_idx_r <= crt_idx_nxt;
    code_r    <= code_nxt;
    if (accept) begin
      req_r  <= in_req_type;
      tid_r  <= in_thread_id;
      cond_r <= COND_BITS'(in_cond_id);
      dur_r  <= TIME_BITS'(in_duration);
      now_r  <= TIME_BITS'(in_now);
      old_r  <= running_r;
    end
    if (state_r == S_DONE && out_free) begin
      out_code_r   <= code_r;
      out_thread_r <= created_r ? 3'(crt_idx_r) : 3'(running_r);
      out_sw_r     <= (running_r != old_r);
      out_live_r   <= 4'(live_r);
      out_sleep_r  <= 4'(sleep_r);
      out_alarm_r  <= 4'(alarm_r);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_result_code    = out_code_r;
  assign out_result_thread  = out_thread_r;
  assign out_switched       = out_sw_r;
  assign out_live_count     = out_live_r;
  assign out_sleeping_count = out_sleep_r;
  assign out_alarm_count    = out_alarm_r;

  // an accepted transaction always goes to dispatch next
  a_accept_dispatch: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> state_r == S_DISP)
    else $error("accepted transaction did not enter dispatch");

  // sleeping and alarm counts never exceed the live count
  a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
    (sleep_r <= live_r) && (alarm_r <= live_r))
    else $error("sleeping or alarm count above live count");

  // a thread switch is only reported with a successful result
  a_switch_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_switched |-> out_result_code == rrts_pkg::RC_OK)
    else $error("switch reported with a failing result code");

  // the running thread only moves during round-robin search or dispatch of run
  a_running_move: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_RR && state_r != S_DISP) |=> $stable(running_r))
    else $error("running thread changed outside scheduling");

endmodule

FILE: hw/rtl/rrts_ram.sv
// rrts_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rrts_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rrts_slot_eval.sv
// rrts_slot_eval: shared compare unit, classifies one slot per cycle
// status decode, wake time against now, condition match; uses rrts_pkg
`timescale 1ns / 1ps

module rrts_slot_eval #(
  parameter int COND_BITS = 16,
  parameter int TIME_BITS = 32
) (
  input  rrts_pkg::status_t     status,
  input  logic [TIME_BITS-1:0]  wake_time,
  input  logic [TIME_BITS-1:0]  now,
  input  logic [COND_BITS-1:0]  slot_cond,
  input  logic [COND_BITS-1:0]  req_cond,
  output rrts_pkg::slot_flags_t flags
);

  always_comb begin
    flags.is_ready      = (status == rrts_pkg::ST_READY);
    flags.is_free       = (status == rrts_pkg::ST_EMPTY) || (status == rrts_pkg::ST_DEAD);
    flags.is_sleep      = (status == rrts_pkg::ST_WAITS) ||
                          (status == rrts_pkg::ST_WAIT_ALARM);
    flags.is_alarm      = (status == rrts_pkg::ST_ALARM) ||
                          (status == rrts_pkg::ST_WAIT_ALARM);
    flags.is_wait_alarm = (status == rrts_pkg::ST_WAIT_ALARM);
    flags.is_live       = flags.is_ready || flags.is_sleep || flags.is_alarm;
    // plain unsigned compare, no wrap handling
    flags.wake_due      = (wake_time < now);
    flags.cond_match    = (slot_cond == req_cond);
  end

endmodule

FILE: sim/tb_top.sv
// tb_top: self-checking bench for round_robin_thread_scheduler_core
// keeps its own model of the slot table, counters and round-robin search and checks
// every result transaction; needs rrts_pkg and the scheduler rtl
`timescale 1ns / 1ps

module tb_top;

  localparam int NTHR         = 8;
  localparam int HOLD_CYCLES  = 200;   // long receiver hold-off for the pressure test
  localparam int STALL_LIMIT  = 2000;  // cycles with no transaction on either side
  localparam int DRAIN_CYCLES = 60;    // wait after the last result, longer than the slowest scheduling request

  // one expected result transaction
  typedef struct packed {
    rrts_pkg::rcode_t code;
    logic [2:0]       thr;
    logic             sw;
    logic [3:0]       live;
    logic [3:0]       sleep;
    logic [3:0]       alarm;
  } sched_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_req_type = '0;
  logic [2:0]  in_thread_id = '0;
  logic [15:0] in_cond_id = '0;
  logic [15:0] in_duration = '0;
  logic [31:0] in_now = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  out_result_code;
  logic [2:0]  out_result_thread;
  logic        out_switched;
  logic [3:0]  out_live_count;
  logic [3:0]  out_sleeping_count;
  logic [3:0]  out_alarm_count;

  round_robin_thread_scheduler_core u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_req_type       (in_req_type),
    .in_thread_id      (in_thread_id),
    .in_cond_id        (in_cond_id),
    .in_duration       (in_duration),
    .in_now            (in_now),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_result_code   (out_result_code),
    .out_result_thread (out_result_thread),
    .out_switched      (out_switched),
    .out_live_count    (out_live_count),
    .out_sleeping_count(out_sleeping_count),
    .out_alarm_count   (out_alarm_count)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // scheduler model: slot table, running thread, search pointer and counters
  // ---------------------------------------------------------------------------
  rrts_pkg::status_t sl_state [NTHR];
  logic [15:0]       sl_cond  [NTHR];
  logic [31:0]       sl_wake  [NTHR];
  logic [2:0]        cur_thr;
  logic [2:0]        rr_ptr;
  int                n_live;
  int                n_sleep;
  int                n_alarm;

  sched_result_t pending_results [$];

  // bench bookkeeping
  int          err_cnt;
  int          results_checked;
  int          req_sent [8];
  int          code_seen [8];
  logic [31:0] tick;            // running time base for well-formed traffic
  logic        calm = 1'b0;     // no idling on either side while set
  int          hold_requests = 0;
  int          holds_done;
  int          hold_left;
  int          stuck_cycles;
  sched_result_t got_expect;

  function automatic void set_slot_ready(int i);
    sl_state[i] = rrts_pkg::ST_READY;
    sl_cond[i]  = '0;
    sl_wake[i]  = '0;
  endfunction

  // alarm sleepers whose wake time lies strictly below now become ready, until the alarm count reaches zero
  function automatic void wake_expired_slots(logic [31:0] t_now);
    int   i;
    logic stop;
    stop = 1'b0;
    for (i = 0; i < NTHR; i++) begin
      if (!stop && (sl_state[i] == rrts_pkg::ST_ALARM ||
                    sl_state[i] == rrts_pkg::ST_WAIT_ALARM) &&
          sl_wake[i] < t_now) begin
        if (sl_state[i] == rrts_pkg::ST_WAIT_ALARM && n_sleep > 0) n_sleep--;
        set_slot_ready(i);
        if (n_alarm > 0) n_alarm--;
        if (n_alarm == 0) stop = 1'b1;
      end
    end
  endfunction

  // wake due alarms, then round-robin search after the pointer for a ready slot
  function automatic rrts_pkg::rcode_t next_thread(logic [31:0] t_now);
    int               i;
    logic             found;
    rrts_pkg::rcode_t rc;
    found = 1'b0;
    wake_expired_slots(t_now);
    for (i = 0; i < NTHR; i++) begin
      if (!found) begin
        rr_ptr = rr_ptr + 3'd1;
        if (sl_state[rr_ptr] == rrts_pkg::ST_READY) begin
          cur_thr = rr_ptr;
          found   = 1'b1;
        end
      end
    end
    if (found) rc = rrts_pkg::RC_OK;
    else if (n_alarm != 0) rc = rrts_pkg::RC_ALARMS;
    else if (n_live != 0) rc = rrts_pkg::RC_DEADLOCK;
    else rc = rrts_pkg::RC_ALL_DEAD;
    return rc;
  endfunction

  // applies one request to the model and returns the result it must produce
  function automatic sched_result_t predict_request(rrts_pkg::req_t rq, logic [2:0] tid,
                                                    logic [15:0] cond, logic [15:0] dur,
                                                    logic [31:0] t_now);
    sched_result_t     r;
    logic [2:0]        prev;
    logic [2:0]        made;
    logic              created;
    int                i;
    rrts_pkg::status_t s;
    prev    = cur_thr;
    created = 1'b0;
    made    = '0;
    r       = '0;
    r.code  = rrts_pkg::RC_OK;
    case (rq)
      rrts_pkg::REQ_CREATE: begin
        r.code = rrts_pkg::RC_FULL;
        if (n_live < NTHR) begin
          for (i = 0; i < NTHR; i++) begin
            if (!created && (sl_state[i] == rrts_pkg::ST_EMPTY ||
                             sl_state[i] == rrts_pkg::ST_DEAD)) begin
              set_slot_ready(i);
              n_live++;
              r.code  = rrts_pkg::RC_OK;
              created = 1'b1;
              made    = 3'(i);
            end
          end
        end
      end
      rrts_pkg::REQ_KILL: begin
        s = sl_state[tid];
        if ((s == rrts_pkg::ST_READY || s == rrts_pkg::ST_WAITS ||
             s == rrts_pkg::ST_ALARM || s == rrts_pkg::ST_WAIT_ALARM) &&
            n_live > 0) n_live--;
        if ((s == rrts_pkg::ST_WAITS || s == rrts_pkg::ST_WAIT_ALARM) && n_sleep > 0)
          n_sleep--;
        if ((s == rrts_pkg::ST_ALARM || s == rrts_pkg::ST_WAIT_ALARM) && n_alarm > 0)
          n_alarm--;
        sl_state[tid] = rrts_pkg::ST_DEAD;
        sl_cond[tid]  = '0;
        if (tid == cur_thr) r.code = next_thread(t_now);
      end
      rrts_pkg::REQ_WAIT, rrts_pkg::REQ_TIMED, rrts_pkg::REQ_SLEEP: begin
        if (sl_state[cur_thr] != rrts_pkg::ST_READY) begin
          r.code = rrts_pkg::RC_ILLEGAL;
        end else begin
          if (rq == rrts_pkg::REQ_WAIT) begin
            sl_state[cur_thr] = rrts_pkg::ST_WAITS;
            sl_cond[cur_thr]  = cond;
            n_sleep++;
          end else begin
            sl_wake[cur_thr] = t_now + {16'd0, dur};
            n_alarm++;
            if (rq == rrts_pkg::REQ_TIMED) begin
              sl_state[cur_thr] = rrts_pkg::ST_WAIT_ALARM;
              sl_cond[cur_thr]  = cond;
              n_sleep++;
            end else begin
              sl_state[cur_thr] = rrts_pkg::ST_ALARM;
            end
          end
          r.code = next_thread(t_now);
        end
      end
      rrts_pkg::REQ_SIGNAL: begin
        for (i = 0; i < NTHR; i++) begin
          s = sl_state[i];
          if ((s == rrts_pkg::ST_WAITS || s == rrts_pkg::ST_WAIT_ALARM) &&
              sl_cond[i] == cond) begin
            if (s == rrts_pkg::ST_WAIT_ALARM && n_alarm > 0) n_alarm--;
            set_slot_ready(i);
            if (n_sleep > 0) n_sleep--;
          end
        end
      end
      rrts_pkg::REQ_YIELD: begin
        r.code = next_thread(t_now);
      end
      default: begin
        if (sl_state[tid] != rrts_pkg::ST_READY) r.code = rrts_pkg::RC_ILLEGAL;
        else cur_thr = tid;
      end
    endcase
    r.thr   = created ? made : cur_thr;
    r.sw    = (cur_thr != prev);
    r.live  = n_live[3:0];
    r.sleep = n_sleep[3:0];
    r.alarm = n_alarm[3:0];
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // request side: one transaction at a time, valid held until accepted
  // ---------------------------------------------------------------------------
  task automatic send_req(input rrts_pkg::req_t rq, input logic [2:0] tid,
                          input logic [15:0] cond, input logic [15:0] dur,
                          input logic [31:0] t_now);
    sched_result_t r;
    // random gaps, mostly short, sometimes longer than a full scheduling pass
    if (!calm && $urandom_range(0, 99) < 30) begin
      in_valid <= 1'b0;
      repeat (($urandom_range(0, 3) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3))
        @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_req_type  <= rq;
    in_thread_id <= tid;
    in_cond_id   <= cond;
    in_duration  <= dur;
    in_now       <= t_now;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // accepted at this edge: advance the model and queue what must come back
    r = predict_request(rq, tid, cond, dur, t_now);
    pending_results.push_back(r);
    req_sent[rq]++;
    code_seen[r.code]++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stall, plus a counted hold-off when one is requested
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      hold_left  <= 0;
      holds_done <= 0;
    end else if (holds_done != hold_requests) begin
      holds_done <= holds_done + 1;
      hold_left  <= HOLD_CYCLES;
      out_stall  <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 30);
    end
  end

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0d, actual %0d", name, exp_v, act_v);
      err_cnt++;
    end
  endfunction

  // every accepted result transaction is matched against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with no request outstanding");
        err_cnt++;
      end else begin
        got_expect = pending_results.pop_front();
        check_field("result_code", 32'(got_expect.code), 32'(out_result_code));
        check_field("result_thread", 32'(got_expect.thr), 32'(out_result_thread));
        check_field("switched", 32'(got_expect.sw), 32'(out_switched));
        check_field("live_count", 32'(got_expect.live), 32'(out_live_count));
        check_field("sleeping_count", 32'(got_expect.sleep), 32'(out_sleeping_count));
        check_field("alarm_count", 32'(got_expect.alarm), 32'(out_alarm_count));
        results_checked++;
      end
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n) begin
      stuck_cycles <= 0;
    end else if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("round_robin_thread_scheduler_core verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  // small set of conditions so that signals actually find waiters
  function automatic logic [15:0] cond_pool();
    logic [15:0] c;
    case ($urandom_range(0, 3))
      0:       c = 16'h0000;
      1:       c = 16'h0001;
      2:       c = 16'h00A5;
      default: c = 16'hFFFF;
    endcase
    return c;
  endfunction

  function automatic logic [2:0] random_ready_slot(logic [2:0] fallback);
    int         i;
    int         n;
    int         pick;
    logic [2:0] r;
    n = 0;
    r = fallback;
    for (i = 0; i < NTHR; i++) if (sl_state[i] == rrts_pkg::ST_READY) n++;
    if (n != 0) begin
      pick = $urandom_range(0, n - 1);
      for (i = 0; i < NTHR; i++) begin
        if (sl_state[i] == rrts_pkg::ST_READY) begin
          if (pick == 0) r = 3'(i);
          pick--;
        end
      end
    end
    return r;
  endfunction

  // request mix, leaning toward create while few threads are alive
  function automatic rrts_pkg::req_t pick_request();
    int             w;
    rrts_pkg::req_t rq;
    w = $urandom_range(0, 99);
    if (n_live < 2 && w < 50) rq = rrts_pkg::REQ_CREATE;
    else if (w < 14) rq = rrts_pkg::REQ_CREATE;
    else if (w < 22) rq = rrts_pkg::REQ_KILL;
    else if (w < 34) rq = rrts_pkg::REQ_WAIT;
    else if (w < 46) rq = rrts_pkg::REQ_TIMED;
    else if (w < 58) rq = rrts_pkg::REQ_SLEEP;
    else if (w < 74) rq = rrts_pkg::REQ_SIGNAL;
    else if (w < 87) rq = rrts_pkg::REQ_YIELD;
    else rq = rrts_pkg::REQ_RUN;
    return rq;
  endfunction

  // ---------------------------------------------------------------------------
  // directed tests
  // ---------------------------------------------------------------------------
  // nothing alive yet: all dead, illegal wait, kill of an empty slot, run on empty slot
  task automatic test_empty_table();
    send_req(rrts_pkg::REQ_YIELD, 3'd0, 16'h0000, 16'h0000, 32'h0000_0000);
    send_req(rrts_pkg::REQ_WAIT, 3'd0, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(rrts_pkg::REQ_KILL, 3'd3, 16'h0000, 16'h0000, 32'h0000_0000);
    send_req(rrts_pkg::REQ_RUN, 3'd7, 16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
  endtask

  // lone thread sleeps on an alarm (only alarms pending), then the alarm expires
  task automatic test_alarm_wake();
    send_req(rrts_pkg::REQ_CREATE, 3'd0, 16'h0000, 16'h0000, 32'h0000_0000);
    send_req(rrts_pkg::REQ_SLEEP, 3'd0, 16'h0000, 16'hFFFF, 32'h0000_0000);
    send_req(rrts_pkg::REQ_CREATE, 3'd7, 16'hFFFF, 16'h0000, 32'h0000_0000);
    send_req(rrts_pkg::REQ_YIELD, 3'd0, 16'h0000, 16'h0000, 32'h0001_0000);
  endtask

  // both threads wait on conditions (deadlock), one is signalled and run directly
  task automatic test_condition_wait();
    send_req(rrts_pkg::REQ_WAIT, 3'd0, 16'hFFFF, 16'h0000, 32'h0001_0000);
    send_req(rrts_pkg::REQ_WAIT, 3'd0, 16'h0000, 16'h0000, 32'h0001_0000);
    send_req(rrts_pkg::REQ_SIGNAL, 3'd0, 16'hFFFF, 16'h0000, 32'h0001_0000);
    send_req(rrts_pkg::REQ_RUN, 3'd1, 16'h0000, 16'h0000, 32'h0001_0000);
  endtask

  // timed wait whose wake time wraps below now, then kill of a waiting thread
  task automatic test_wrap_and_kill();
    send_req(rrts_pkg::REQ_TIMED, 3'd0, 16'h0000, 16'hFFFF, 32'hFFFF_FFFF);
    send_req(rrts_pkg::REQ_KILL, 3'd0, 16'h0000, 16'h0000, 32'hFFFF_FFFF);
  endtask

  // fill every slot, reusing dead ones, then one create too many
  task automatic test_table_full();
    repeat (NTHR) send_req(rrts_pkg::REQ_CREATE, 3'd0, 16'h0000, 16'h0000, 32'h0000_0010);
  endtask

  // signal with no waiter, kill of the running thread, run on the dead slot
  task automatic test_signal_and_kill();
    logic [2:0] victim;
    victim = cur_thr;
    send_req(rrts_pkg::REQ_SIGNAL, 3'd0, 16'hABCD, 16'h0000, 32'h0000_0020);
    send_req(rrts_pkg::REQ_KILL, victim, 16'h0000, 16'h0000, 32'h0000_0020);
    send_req(rrts_pkg::REQ_RUN, victim, 16'h0000, 16'h0000, 32'h0000_0020);
  endtask

  // ---------------------------------------------------------------------------
  // random traffic: mostly well-formed requests on a moving time base, some noise
  // ---------------------------------------------------------------------------
  task automatic test_random_traffic(input int n_items);
    int             k;
    rrts_pkg::req_t rq;
    logic [2:0]     tid;
    logic [15:0]    cond;
    logic [15:0]    dur;
    logic [31:0]    t_now;
    for (k = 0; k < n_items; k++) begin
      tid  = 3'($urandom_range(0, 7));
      cond = cond_pool();
      dur  = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                          : 16'($urandom_range(0, 40));
      tick = tick + $urandom_range(0, 12);
      // occasional jump of the time base, wrap region included
      if ($urandom_range(0, 29) == 0) tick = $urandom();
      t_now = tick;
      if ($urandom_range(0, 99) < 10) begin
        // noise: any request with any field values
        rq    = 3'($urandom_range(0, 7));
        cond  = 16'($urandom_range(0, 65535));
        dur   = 16'($urandom_range(0, 65535));
        t_now = $urandom();
      end else begin
        rq = pick_request();
        if (rq == rrts_pkg::REQ_KILL && $urandom_range(0, 1) == 1) tid = cur_thr;
        if (rq == rrts_pkg::REQ_RUN && $urandom_range(0, 3) != 0)
          tid = random_ready_slot(tid);
      end
      send_req(rq, tid, cond, dur, t_now);
    end
  endtask

  // no idling on either side for a long stretch
  task automatic test_full_rate(input int n_items);
    calm <= 1'b1;
    test_random_traffic(n_items);
    calm <= 1'b0;
  endtask

  // receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure(input int n_items);
    hold_requests <= hold_requests + 1;
    test_random_traffic(n_items);
  endtask

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin
    int i;
    // model state after reset
    for (i = 0; i < NTHR; i++) begin
      sl_state[i] = rrts_pkg::ST_EMPTY;
      sl_cond[i]  = '0;
      sl_wake[i]  = '0;
    end
    for (i = 0; i < 8; i++) begin
      req_sent[i]  = 0;
      code_seen[i] = 0;
    end
    cur_thr         = '0;
    rr_ptr          = '0;
    n_live          = 0;
    n_sleep         = 0;
    n_alarm         = 0;
    err_cnt         = 0;
    results_checked = 0;
    tick            = '0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    test_empty_table();
    test_alarm_wake();
    test_condition_wait();
    test_wrap_and_kill();
    test_table_full();
    test_signal_and_kill();
    test_random_traffic(400);
    test_full_rate(150);
    test_backpressure(100);

    // drain: all results back, then a few scheduling passes for anything extra
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $write("run covered %0d results; requests create %0d kill %0d wait %0d",
           results_checked, req_sent[rrts_pkg::REQ_CREATE], req_sent[rrts_pkg::REQ_KILL],
           req_sent[rrts_pkg::REQ_WAIT]);
    $display(" timed %0d sleep %0d signal %0d yield %0d run %0d",
             req_sent[rrts_pkg::REQ_TIMED], req_sent[rrts_pkg::REQ_SLEEP],
             req_sent[rrts_pkg::REQ_SIGNAL], req_sent[rrts_pkg::REQ_YIELD],
             req_sent[rrts_pkg::REQ_RUN]);
    $write("codes seen: ok %0d illegal %0d full %0d",
           code_seen[rrts_pkg::RC_OK], code_seen[rrts_pkg::RC_ILLEGAL],
           code_seen[rrts_pkg::RC_FULL]);
    $display(" alarms pending %0d deadlock %0d all dead %0d",
             code_seen[rrts_pkg::RC_ALARMS], code_seen[rrts_pkg::RC_DEADLOCK],
             code_seen[rrts_pkg::RC_ALL_DEAD]);
    if (err_cnt == 0) begin
      $display("round_robin_thread_scheduler_core verification clean");
    end else begin
      $display("round_robin_thread_scheduler_core verification failed");
    end
    $finish;
  end

endmodule
